### rtl/core/ormr_pkg.sv
package ormr_pkg;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
  localparam int unsigned OFF_W       = 8;
  localparam int unsigned ADDR_W      = SLOT_W + OFF_W;
  localparam int unsigned MAX_PAYLOAD = 255;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [OFF_W:0]    off_ext_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERWRITE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FLUSHED   = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic    rd_hit;
    logic    last;
    status_t status;
  } beat_ctl_t;

  function automatic slot_t next_slot(input slot_t s);
    slot_t r;
    r = (s == slot_t'(SLOT_COUNT - 1)) ? '0 : s + slot_t'(1);
    return r;
  endfunction

endpackage

### rtl/core/ormr_if.sv
interface ormr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface ormr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       last_byte;
  logic [2:0] status;

  modport source (output valid, output read_byte, output last_byte, output status,
                  input ready);
  modport sink (input valid, input read_byte, input last_byte, input status,
                output ready);
endinterface

### rtl/core/overwrite_oldest_message_ring.sv
// Channel  Dir  Beat fields                      Handshake
// in_ch    in   op, data_byte                    valid/ready
// out_ch   out  read_byte, last_byte, status     valid/ready
//
// One item per cycle while the output is not stalled; once its beat is accepted, a
// result passes through the payload RAM read register, then the output register.
// Reset is synchronous, active low; it clears slot indexes, counts and valids.
// The payload and length stores are not cleared; no sweep follows reset.
// A stalled output holds its beat while one more item still enters.
module overwrite_oldest_message_ring (
  input  logic       clk,
  input  logic       rst_n,
  ormr_in_if.sink    in_ch,
  ormr_out_if.source out_ch
);

  ormr_pkg::slot_t write_slot_r, write_slot_nxt;
  ormr_pkg::slot_t read_slot_r, read_slot_nxt;
  ormr_pkg::off_t  fill_count_r, fill_count_nxt;
  ormr_pkg::off_t  read_offset_r, read_offset_nxt;
  ormr_pkg::off_t  length_r [ormr_pkg::SLOT_COUNT];
  logic            len_we;

  logic                  beat_valid_r, beat_valid_nxt;
  ormr_pkg::beat_ctl_t   beat_ctl_r, beat_ctl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ormr_pkg::byte_t       out_read_byte_r;
  logic                  out_last_r;
  ormr_pkg::status_t     out_status_r;

  ormr_pkg::ram_req_t    ram_req;
  ormr_pkg::byte_t       ram_q;
  ormr_pkg::op_t         op;
  ormr_pkg::off_t        len_cur;
  logic                  in_acc;
  logic                  beat_adv;

  ormr_payload_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  assign op       = ormr_pkg::op_t'(in_ch.op);
  assign len_cur  = length_r[read_slot_r];
  assign beat_adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !beat_valid_r || beat_adv;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    write_slot_nxt  = write_slot_r;
    read_slot_nxt   = read_slot_r;
    fill_count_nxt  = fill_count_r;
    read_offset_nxt = read_offset_r;
    len_we          = 1'b0;
    beat_ctl_nxt    = '{rd_hit: 1'b0, last: 1'b0, status: ormr_pkg::ST_OK};
    ram_req.we      = 1'b0;
    ram_req.waddr   = {write_slot_r, fill_count_r};
    ram_req.wdata   = in_ch.data_byte;
    ram_req.re      = 1'b0;
    ram_req.raddr   = {read_slot_r, read_offset_r};
    unique case (op)
      ormr_pkg::OP_PUSH: begin
        if (fill_count_r < ormr_pkg::off_t'(ormr_pkg::MAX_PAYLOAD)) begin
          ram_req.we     = in_acc;
          fill_count_nxt = fill_count_r + ormr_pkg::off_t'(1);
        end else begin
          beat_ctl_nxt.status = ormr_pkg::ST_DROPPED;
        end
      end
      ormr_pkg::OP_COMMIT: begin
        len_we         = in_acc;
        fill_count_nxt = '0;
        write_slot_nxt = ormr_pkg::next_slot(write_slot_r);
        if (ormr_pkg::next_slot(write_slot_r) == read_slot_r) begin
          read_slot_nxt       = ormr_pkg::next_slot(read_slot_r);
          read_offset_nxt     = '0;
          beat_ctl_nxt.status = ormr_pkg::ST_OVERWRITE;
        end
      end
      ormr_pkg::OP_READ: begin
        if (write_slot_r == read_slot_r) begin
          beat_ctl_nxt.status = ormr_pkg::ST_EMPTY;
        end else if (len_cur == '0) begin
          write_slot_nxt      = read_slot_r;
          read_offset_nxt     = '0;
          fill_count_nxt      = '0;
          beat_ctl_nxt.status = ormr_pkg::ST_FLUSHED;
        end else begin
          beat_ctl_nxt.rd_hit = 1'b1;
          ram_req.re          = in_acc;
          if ({1'b0, read_offset_r} + ormr_pkg::off_ext_t'(1) >= {1'b0, len_cur}) begin
            beat_ctl_nxt.last = 1'b1;
            read_offset_nxt   = '0;
            read_slot_nxt     = ormr_pkg::next_slot(read_slot_r);
          end else begin
            read_offset_nxt = read_offset_r + ormr_pkg::off_t'(1);
          end
        end
      end
      ormr_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    beat_valid_nxt = beat_valid_r;
    if (in_acc) begin
      beat_valid_nxt = 1'b1;
    end else if (beat_adv) begin
      beat_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (beat_valid_r && beat_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r  <= '0;
      read_slot_r   <= '0;
      fill_count_r  <= '0;
      read_offset_r <= '0;
      beat_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        write_slot_r  <= write_slot_nxt;
        read_slot_r   <= read_slot_nxt;
        fill_count_r  <= fill_count_nxt;
        read_offset_r <= read_offset_nxt;
      end
      beat_valid_r <= beat_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      length_r[write_slot_r] <= fill_count_r;
    end
    if (in_acc) begin
      beat_ctl_r <= beat_ctl_nxt;
    end
    if (beat_valid_r && beat_adv) begin
      out_read_byte_r <= beat_ctl_r.rd_hit ? ram_q : '0;
      out_last_r      <= beat_ctl_r.last;
      out_status_r    <= beat_ctl_r.status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = out_read_byte_r;
  assign out_ch.last_byte = out_last_r;
  assign out_ch.status    = out_status_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= ormr_pkg::off_t'(ormr_pkg::MAX_PAYLOAD))
    else $error("fill count past payload limit");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == ormr_pkg::OP_PUSH &&
    fill_count_r < ormr_pkg::off_t'(ormr_pkg::MAX_PAYLOAD)
    |=> fill_count_r == $past(fill_count_r) + ormr_pkg::off_t'(1))
    else $error("accepted push did not advance fill count");

  a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
    beat_valid_r && !beat_adv |=> beat_valid_r && $stable(beat_ctl_r))
    else $error("pending beat lost while output stalled");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    beat_valid_r && beat_ctl_r.last |-> beat_ctl_r.rd_hit &&
    beat_ctl_r.status == ormr_pkg::ST_OK)
    else $error("last byte flagged without a read hit");
`endif

endmodule

### rtl/core/ormr_payload_ram.sv
module ormr_payload_ram (
  input  logic              clk,
  input  ormr_pkg::ram_req_t req,
  output ormr_pkg::byte_t    rd_data
);

  ormr_pkg::byte_t mem [2**ormr_pkg::ADDR_W];
  ormr_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
